// ----- rtl/dqt_pkg.sv -----
// Types, constants and helpers shared by the dual quaternion transform.
`default_nettype none
package dqt_pkg;

  localparam int DQT_WORD_BITS = 32;
  localparam int DQT_FRAC_BITS = 24;
  localparam int DQT_CFG_IDX_BITS = 3;
  // Register stages in one dual quaternion multiply unit
  localparam int DQT_UNIT_LAT = 4;

  localparam logic [1:0] MODE_PRODUCT = 2'd0;
  localparam logic [1:0] MODE_LINE    = 2'd1;
  localparam logic [1:0] MODE_POINT   = 2'd2;

  typedef logic signed [DQT_WORD_BITS-1:0] word_t;
  typedef word_t dq_t [8];

  localparam word_t WORD_MAX = {1'b0, {(DQT_WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DQT_WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [1:0] mode;
    logic signed [DQT_WORD_BITS-1:0] operand_0;
    logic signed [DQT_WORD_BITS-1:0] operand_1;
    logic signed [DQT_WORD_BITS-1:0] operand_2;
    logic signed [DQT_WORD_BITS-1:0] operand_3;
    logic signed [DQT_WORD_BITS-1:0] operand_4;
    logic signed [DQT_WORD_BITS-1:0] operand_5;
    logic signed [DQT_WORD_BITS-1:0] operand_6;
    logic signed [DQT_WORD_BITS-1:0] operand_7;
  } in_t;

  typedef struct packed {
    logic signed [DQT_WORD_BITS-1:0] result_0;
    logic signed [DQT_WORD_BITS-1:0] result_1;
    logic signed [DQT_WORD_BITS-1:0] result_2;
    logic signed [DQT_WORD_BITS-1:0] result_3;
    logic signed [DQT_WORD_BITS-1:0] result_4;
    logic signed [DQT_WORD_BITS-1:0] result_5;
    logic signed [DQT_WORD_BITS-1:0] result_6;
    logic signed [DQT_WORD_BITS-1:0] result_7;
    logic overflow;
  } out_t;

  // Quaternion product terms: component t/4 sums p[QI]*q[QJ], minus where QNEG
  localparam int QI [16] = '{0, 1, 2, 3,  0, 1, 2, 3,  0, 2, 3, 1,  0, 3, 1, 2};
  localparam int QJ [16] = '{0, 1, 2, 3,  1, 0, 3, 2,  2, 0, 1, 3,  3, 0, 2, 1};
  localparam bit QNEG [16] = '{0, 1, 1, 1,  0, 0, 0, 1,  0, 0, 0, 1,  0, 0, 0, 1};
  // Real, dual-from-q and dual-from-p partial products of a dual product
  localparam int P_OFF [3] = '{0, 0, 4};
  localparam int Q_OFF [3] = '{0, 4, 0};

  function automatic logic acc_ovf(logic signed [DQT_WORD_BITS+1:0] v);
    acc_ovf = v[DQT_WORD_BITS+1:DQT_WORD_BITS-1] != {3{v[DQT_WORD_BITS-1]}};
  endfunction

  function automatic word_t sat_acc(logic signed [DQT_WORD_BITS+1:0] v);
    if (!acc_ovf(v)) begin
      sat_acc = v[DQT_WORD_BITS-1:0];
    end else if (v[DQT_WORD_BITS+1]) begin
      sat_acc = WORD_MIN;
    end else begin
      sat_acc = WORD_MAX;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dqt_dqmul.sv -----
// Pipelined saturating fixed-point dual quaternion multiply unit.
`default_nettype none
module dqt_dqmul #(
  parameter int FRAC_BITS = dqt_pkg::DQT_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  dqt_pkg::dq_t p,
  input  dqt_pkg::dq_t q,
  output logic         out_valid,
  output dqt_pkg::dq_t r,
  output logic         ovf
);
  import dqt_pkg::*;

  localparam int W  = DQT_WORD_BITS;
  localparam int PW = 2 * W;
  localparam int SW = PW - FRAC_BITS;

  logic v1_r, v2_r, v3_r, v4_r;
  logic ov2_r, ov3_r, ov4_r;
  logic signed [PW-1:0] prod_r [3][16];
  word_t sp_r [3][16];
  word_t s3_r [3][4];
  word_t r_r [8];
  logic [47:0] sat2;
  logic [11:0] sat3;
  logic [3:0] sat4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ov2_r <= |sat2;
    ov3_r <= ov2_r | (|sat3);
    ov4_r <= ov3_r | (|sat4);
  end

  for (genvar g = 0; g < 3; g++) begin : g_part
    for (genvar t = 0; t < 16; t++) begin : g_term
      word_t a, b;
      logic signed [SW-1:0] sh;
      logic fits;
      assign a = p[P_OFF[g] + QI[t]];
      assign b = q[Q_OFF[g] + QJ[t]];

      // Exact product
      always_ff @(posedge clk) begin
        prod_r[g][t] <= a * b;
      end

      // Floor by the fraction bits, saturate
      assign sh   = SW'(prod_r[g][t] >>> FRAC_BITS);
      assign fits = sh[SW-1:W-1] == {(SW-W+1){sh[W-1]}};
      assign sat2[g*16+t] = !fits;
      always_ff @(posedge clk) begin
        if (fits) begin
          sp_r[g][t] <= sh[W-1:0];
        end else if (sh[SW-1]) begin
          sp_r[g][t] <= WORD_MIN;
        end else begin
          sp_r[g][t] <= WORD_MAX;
        end
      end
    end

    for (genvar c = 0; c < 4; c++) begin : g_comp
      logic signed [W+1:0] acc;
      always_comb begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          if (QNEG[c*4+k]) begin
            acc = acc - (W+2)'(sp_r[g][c*4+k]);
          end else begin
            acc = acc + (W+2)'(sp_r[g][c*4+k]);
          end
        end
      end
      assign sat3[g*4+c] = acc_ovf(acc);
      always_ff @(posedge clk) begin
        s3_r[g][c] <= sat_acc(acc);
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_dual
    logic signed [W+1:0] dsum;
    assign dsum = (W+2)'(s3_r[1][c]) + (W+2)'(s3_r[2][c]);
    assign sat4[c] = acc_ovf(dsum);
    always_ff @(posedge clk) begin
      r_r[c]   <= s3_r[0][c];
      r_r[4+c] <= sat_acc(dsum);
    end
  end

  assign out_valid = v4_r;
  assign r         = r_r;
  assign ovf       = ov4_r;

endmodule
`default_nettype wire

// ----- rtl/dual_quaternion_transform.sv -----
// Dual quaternion rigid transform: product, line sandwich and point sandwich.
//
//   channel | ports                          | handshake
//   input   | start, busy, in_data           | accepted when start && !busy
//   result  | out_valid, out_data            | one-cycle strobe, no back-pressure
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// One item per cycle; each result passes through two 4-stage dual product
// units back to back plus the output register.
// Every mode takes the same path length; the product mode bypasses the
// second unit through a matching delay line. busy stays low.
// Synchronous reset clears the valid bits and loads the identity pose.
`default_nettype none
module dual_quaternion_transform #(
  parameter int FRAC_BITS = dqt_pkg::DQT_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  dqt_pkg::in_t                           in_data,
  output logic                                   out_valid,
  output dqt_pkg::out_t                          out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dqt_pkg::DQT_CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [dqt_pkg::DQT_WORD_BITS-1:0]      cfg_data
);
  import dqt_pkg::*;

  localparam int W = DQT_WORD_BITS;
  localparam int L = DQT_UNIT_LAT;

  word_t pose_r [8];
  dq_t conj_line, conj_point, x, pa, qa, pb, qb, t1, rb;
  logic [7:0] is_min;
  logic flag_line, flag_point, in_cf, a_valid, a_ovf, b_valid, b_ovf;
  logic [1:0] md_r [2*L];
  logic cf_r [2*L];
  dq_t byp_r [L];
  logic bov_r [L];
  logic [1:0] md_b, md_o;
  logic bypass;
  logic out_valid_r;
  out_t out_data_r;
  dq_t res;
  logic res_ovf;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i < 8; i++) begin
        pose_r[i] <= '0;
      end
      pose_r[0] <= {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      pose_r[cfg_index] <= cfg_data;
    end
  end

  // Conjugates of the pose; negating the most negative word saturates
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      is_min[i] = pose_r[i] == WORD_MIN;
    end
    conj_line[0]  = pose_r[0];
    conj_line[4]  = pose_r[4];
    conj_point[0] = pose_r[0];
    conj_point[4] = is_min[4] ? WORD_MAX : -pose_r[4];
    for (int i = 1; i < 4; i++) begin
      conj_line[i]    = is_min[i] ? WORD_MAX : -pose_r[i];
      conj_line[4+i]  = is_min[4+i] ? WORD_MAX : -pose_r[4+i];
      conj_point[i]   = conj_line[i];
      conj_point[4+i] = pose_r[4+i];
    end
    flag_line  = is_min[1] | is_min[2] | is_min[3] | is_min[5] | is_min[6] | is_min[7];
    flag_point = is_min[1] | is_min[2] | is_min[3] | is_min[4];
  end

  assign x[0] = in_data.operand_0;
  assign x[1] = in_data.operand_1;
  assign x[2] = in_data.operand_2;
  assign x[3] = in_data.operand_3;
  assign x[4] = in_data.operand_4;
  assign x[5] = in_data.operand_5;
  assign x[6] = in_data.operand_6;
  assign x[7] = in_data.operand_7;

  // First unit: X*conj for lines, pose*X otherwise
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pa[i] = (in_data.mode == MODE_LINE) ? x[i] : pose_r[i];
      qa[i] = (in_data.mode == MODE_LINE) ? conj_line[i] : x[i];
    end
    case (in_data.mode)
      MODE_LINE:  in_cf = flag_line;
      MODE_POINT: in_cf = flag_point;
      default:    in_cf = 1'b0;
    endcase
  end

  dqt_dqmul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .p         (pa),
    .q         (qa),
    .out_valid (a_valid),
    .r         (t1),
    .ovf       (a_ovf)
  );

  // Mode and conjugate flag travel alongside both units
  always_ff @(posedge clk) begin
    md_r[0] <= in_data.mode;
    cf_r[0] <= in_cf;
    for (int k = 1; k < 2*L; k++) begin
      md_r[k] <= md_r[k-1];
      cf_r[k] <= cf_r[k-1];
    end
    byp_r[0] <= t1;
    bov_r[0] <= a_ovf;
    for (int k = 1; k < L; k++) begin
      byp_r[k] <= byp_r[k-1];
      bov_r[k] <= bov_r[k-1];
    end
  end

  assign md_b = md_r[L-1];

  // Second unit: pose*t1 for lines, t1*conj for points
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pb[i] = (md_b == MODE_LINE) ? pose_r[i] : t1[i];
      qb[i] = (md_b == MODE_LINE) ? t1[i] : conj_point[i];
    end
  end

  dqt_dqmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .p         (pb),
    .q         (qb),
    .out_valid (b_valid),
    .r         (rb),
    .ovf       (b_ovf)
  );

  assign md_o   = md_r[2*L-1];
  assign bypass = (md_o != MODE_LINE) && (md_o != MODE_POINT);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      res[i] = bypass ? byp_r[L-1][i] : rb[i];
    end
    res_ovf = cf_r[2*L-1] | bov_r[L-1] | (!bypass & b_ovf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.result_0 <= res[0];
    out_data_r.result_1 <= res[1];
    out_data_r.result_2 <= res[2];
    out_data_r.result_3 <= res[3];
    out_data_r.result_4 <= res[4];
    out_data_r.result_5 <= res[5];
    out_data_r.result_6 <= res[6];
    out_data_r.result_7 <= res[7];
    out_data_r.overflow <= res_ovf;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(2*L+1) out_valid)
    else $error("transfer produced no result at the expected cycle");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_conj_flag: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid && cf_r[2*L-1] |=> out_data.overflow)
    else $error("conjugate saturation lost from overflow");

  a_unit_align: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid |-> $past(a_valid, L))
    else $error("second unit valid out of step with first");

endmodule
`default_nettype wire
